/* rtl/core/lz78_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and control/status types for the LZ78 phrase parser.
// Used by lz78_ctrl, lz78_dp and lz78_phrase_parser.
package lz78_pkg;

    localparam int MAX_NODES     = 4096;
    // Power of two: the home slot is taken from product bits directly.
    localparam int TABLE_SLOTS   = 8192;
    localparam int POSITION_BITS = 24;

    localparam int SYM_W    = 8;
    localparam int OFFSET_W = 24;
    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int KEY_W    = NODE_W + SYM_W;
    // valid + key + child
    localparam int ENTRY_W  = 1 + KEY_W + NODE_W;

    // Multiplicative hash; only the low HASH_W product bits are ever used.
    localparam int          HASH_SHIFT = 7;
    localparam int          HASH_W     = SLOT_W + HASH_SHIFT;
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;

    typedef struct packed {
        logic clear;    // write one blank entry of the table sweep
        logic load;     // capture the input item and its home slot
        logic advance;  // step to the next slot of the probe run
        logic take_hit; // follow the matched edge
        logic commit;   // store the new edge if there is room and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hit;
        logic miss;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/lz78_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the LZ78 phrase parser: table sweep, accept, probe, commit.
// Depends on lz78_pkg for the command and status types.
module lz78_ctrl
    import lz78_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (status.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_IDLE;
                end else if (status.miss) begin
                    // hold here until the result register can take the phrase
                    if (status.out_free) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/lz78_dp.sv */
`timescale 1ns / 1ps
// Datapath of the LZ78 phrase parser: hashed edge table, walk state, result register.
// Depends on lz78_pkg; driven by commands from lz78_ctrl.
module lz78_dp
    import lz78_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [SYM_W-1:0]    s_symbol,
    input  logic                s_last_symbol,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NODE_W-1:0]   m_node_id,
    output logic [NODE_W-1:0]   m_parent_id,
    output logic [SYM_W-1:0]    m_edge_symbol,
    output logic [OFFSET_W-1:0] m_start_offset,
    output logic                m_dict_full
);

    localparam logic [HASH_W-1:0]        HASH_MULT_LO = HASH_W'(HASH_MULT);
    localparam logic [SLOT_W-1:0]        LAST_SLOT    = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX      = '1;

    // edge table
    logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               mem_we;

    // walk state
    logic [NODE_W-1:0]        cur_node_reg,  cur_node_next;
    logic [CNT_W-1:0]         node_count_reg, node_count_next;
    logic [POSITION_BITS-1:0] text_pos_reg,  text_pos_next;
    logic [POSITION_BITS-1:0] phrase_start_reg, phrase_start_next;
    logic [SLOT_W-1:0]        clr_addr_reg;

    // item being parsed
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] probe_cnt_reg;

    // result register
    logic                m_valid_reg;
    logic [NODE_W-1:0]   node_id_reg;
    logic [NODE_W-1:0]   parent_id_reg;
    logic [SYM_W-1:0]    edge_sym_reg;
    logic [OFFSET_W-1:0] start_off_reg;
    logic                full_reg;

    logic [KEY_W-1:0]  key_in;
    logic [HASH_W-1:0] prod;
    logic [SLOT_W-1:0] slot_inc;
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic [NODE_W-1:0] rd_child;
    logic              hit;
    logic              dict_full;
    logic              finish;

    always_comb begin
        key_in   = {cur_node_reg, s_symbol};
        prod     = HASH_W'(key_in) * HASH_MULT_LO;
        slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

        rd_valid = rd_data_reg[ENTRY_W-1];
        rd_key   = rd_data_reg[ENTRY_W-2 -: KEY_W];
        rd_child = rd_data_reg[NODE_W-1:0];
        hit      = rd_valid && (rd_key == key_reg);

        status.clear_done = (clr_addr_reg == LAST_SLOT);
        status.hit        = hit;
        // an occupied slot at the end of a full-length run means no free slot
        status.miss       = !rd_valid || (!hit && probe_cnt_reg == LAST_SLOT);
        status.out_free   = !m_valid_reg || m_ready;

        dict_full = (node_count_reg >= CNT_W'(MAX_NODES)) || rd_valid;
    end

    // table ports
    always_comb begin
        rd_addr = cmd.advance ? slot_inc : slot_reg;
        mem_we  = cmd.clear || (cmd.commit && !dict_full);
        wr_addr = cmd.clear ? clr_addr_reg : slot_reg;
        wr_data = cmd.clear ? '0 : {1'b1, key_reg, node_count_reg[NODE_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // walk state update
    always_comb begin
        finish            = cmd.take_hit || cmd.commit;
        cur_node_next     = cur_node_reg;
        text_pos_next     = text_pos_reg;
        phrase_start_next = phrase_start_reg;
        node_count_next   = node_count_reg;

        if (cmd.load && cur_node_reg == '0) begin
            phrase_start_next = text_pos_reg;
        end
        if (cmd.commit && !dict_full) begin
            node_count_next = node_count_reg + 1'b1;
        end
        if (finish) begin
            if (last_reg) begin
                cur_node_next     = '0;
                text_pos_next     = '0;
                phrase_start_next = '0;
            end else begin
                cur_node_next = cmd.take_hit ? rd_child : '0;
                if (text_pos_reg != POS_MAX) begin
                    text_pos_next = text_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_node_reg     <= '0;
            node_count_reg   <= CNT_W'(1);
            text_pos_reg     <= '0;
            phrase_start_reg <= '0;
            clr_addr_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            cur_node_reg     <= cur_node_next;
            node_count_reg   <= node_count_next;
            text_pos_reg     <= text_pos_next;
            phrase_start_reg <= phrase_start_next;
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sym_reg       <= s_symbol;
            last_reg      <= s_last_symbol;
            key_reg       <= key_in;
            slot_reg      <= prod[HASH_W-1:HASH_SHIFT];
            probe_cnt_reg <= '0;
        end else if (cmd.advance) begin
            slot_reg      <= slot_inc;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.commit) begin
            node_id_reg   <= dict_full ? '0 : node_count_reg[NODE_W-1:0];
            parent_id_reg <= cur_node_reg;
            edge_sym_reg  <= sym_reg;
            start_off_reg <= OFFSET_W'(phrase_start_reg);
            full_reg      <= dict_full;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_node_id      = node_id_reg;
    assign m_parent_id    = parent_id_reg;
    assign m_edge_symbol  = edge_sym_reg;
    assign m_start_offset = start_off_reg;
    assign m_dict_full    = full_reg;

endmodule

/* rtl/core/lz78_phrase_parser.sv */
`timescale 1ns / 1ps
// LZ78 phrase parser: one text symbol in, at most one new dictionary phrase out.
// Top level joining lz78_ctrl and lz78_dp; depends on lz78_pkg.
//
// Usage:
//   Input channel (s_*): one text symbol per transfer; s_last_symbol marks the
//   end of a text. After it the walk, phrase start and text position return
//   to zero while the dictionary is kept.
//   Result channel (m_*): one transfer per symbol that ends a phrase, carrying
//   the new node, its parent, the edge symbol and the phrase start position.
//   m_dict_full flags a phrase that found no room; its m_node_id is zero.
//   Table and flow: the dictionary is a linear-probed hash table in
//   a single-port-read memory. A symbol passes through accept, table read
//   and compare, stepping to the next slot on each slot collision; a result
//   is visible on m_valid the cycle after the commit. One symbol is in flight
//   at a time, so the table read/compare loop sets the rate.
//   Reset: all 8192 table slots are swept blank, one slot per cycle, while
//   s_ready stays low.
//   Stall: the result sits in an output register; the next symbol is still
//   taken while it waits. A second phrase holds in the compare state until
//   the receiver takes the first, which also stalls the input.
module lz78_phrase_parser
    import lz78_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SYM_W-1:0]    s_symbol,
    input  logic                s_last_symbol,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NODE_W-1:0]   m_node_id,
    output logic [NODE_W-1:0]   m_parent_id,
    output logic [SYM_W-1:0]    m_edge_symbol,
    output logic [OFFSET_W-1:0] m_start_offset,
    output logic                m_dict_full
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: sweep, accept, probe, commit
    lz78_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, walk state and result register
    lz78_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_symbol       (s_symbol),
        .s_last_symbol  (s_last_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_id      (m_node_id),
        .m_parent_id    (m_parent_id),
        .m_edge_symbol  (m_edge_symbol),
        .m_start_offset (m_start_offset),
        .m_dict_full    (m_dict_full)
    );

`ifndef SYNTHESIS
    // a phrase that found no room carries no node number
    a_full_no_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dict_full |-> m_node_id == '0)
        else $error("dict_full result with nonzero node_id");

    // nodes are numbered in creation order, so a new node follows its parent
    a_node_after_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dict_full |-> m_node_id > m_parent_id)
        else $error("new node not numbered after its parent");

    // one symbol at a time: after an accept, the input stays closed
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a symbol is in flight");

    // a result is only loaded on a miss, while the result register is free or being emptied
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> status.out_free && status.miss)
        else $error("result loaded over a pending transfer");
`endif

endmodule

/* verif/lz78_phrase_checker.sv */
`timescale 1ns / 1ps
// Result checker for lz78_phrase_parser: watches both channels, predicts the new
// dictionary phrases and compares every result transfer. Depends on lz78_pkg.
module lz78_phrase_checker
    import lz78_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [SYM_W-1:0]    s_symbol,
    input  logic                s_last_symbol,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [NODE_W-1:0]   m_node_id,
    input  logic [NODE_W-1:0]   m_parent_id,
    input  logic [SYM_W-1:0]    m_edge_symbol,
    input  logic [OFFSET_W-1:0] m_start_offset,
    input  logic                m_dict_full,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   parent;
        logic [SYM_W-1:0]    sym;
        logic [OFFSET_W-1:0] offset;
        logic                full;
    } phrase_t;

    // Exact trie: {node, symbol} -> child node.
    logic [NODE_W-1:0]        child_of [logic [KEY_W-1:0]];
    logic [NODE_W-1:0]        walk_node;
    logic [POSITION_BITS-1:0] phrase_pos;
    logic [POSITION_BITS-1:0] text_pos;
    logic [CNT_W-1:0]         nodes_used;
    phrase_t                  phrases_due [$];
    phrase_t                  want_phrase;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("checker: %s got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Walk one symbol; queue the phrase it closes, if any.
    task automatic absorb_symbol(input logic [SYM_W-1:0] sym, input logic last);
        phrase_t          p;
        logic [KEY_W-1:0] key;
        if (walk_node == '0) begin
            phrase_pos = text_pos;
        end
        key = {walk_node, sym};
        if (child_of.exists(key)) begin
            walk_node = child_of[key];
        end else begin
            // The table always has a free slot since it holds more slots than
            // nodes, so only the node limit can refuse a phrase.
            p.parent = walk_node;
            p.sym    = sym;
            p.offset = phrase_pos[OFFSET_W-1:0];
            p.full   = (nodes_used >= MAX_NODES);
            p.node   = '0;
            if (!p.full) begin
                p.node        = nodes_used[NODE_W-1:0];
                child_of[key] = p.node;
                nodes_used++;
            end
            phrases_due = {phrases_due, p};
            walk_node = '0;
        end
        if (text_pos != '1) begin
            text_pos++;
        end
        if (last) begin
            walk_node  = '0;
            phrase_pos = '0;
            text_pos   = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            child_of.delete();
            phrases_due.delete();
            walk_node  = '0;
            phrase_pos = '0;
            text_pos   = '0;
            nodes_used = 1;
        end else begin
            // Compare first: a result can never come from a symbol taken at the same edge.
            if (m_valid && m_ready) begin
                if (phrases_due.size() == 0) begin
                    report_mismatch("unexpected result, node_id", m_node_id, 0);
                end else begin
                    want_phrase = phrases_due.pop_front();
                    if (m_node_id !== want_phrase.node)
                        report_mismatch("node_id", m_node_id, want_phrase.node);
                    if (m_parent_id !== want_phrase.parent)
                        report_mismatch("parent_id", m_parent_id, want_phrase.parent);
                    if (m_edge_symbol !== want_phrase.sym)
                        report_mismatch("edge_symbol", m_edge_symbol, want_phrase.sym);
                    if (m_start_offset !== want_phrase.offset)
                        report_mismatch("start_offset", m_start_offset, want_phrase.offset);
                    if (m_dict_full !== want_phrase.full)
                        report_mismatch("dict_full", m_dict_full, want_phrase.full);
                end
            end
            if (s_valid && s_ready) begin
                absorb_symbol(s_symbol, s_last_symbol);
            end
        end
        pending <= phrases_due.size();
    end

endmodule

/* verif/lz78_phrase_parser_tb.sv */
`timescale 1ns / 1ps
// Testbench top for lz78_phrase_parser: drives symbol texts and result back-pressure,
// gives the verdict. Depends on lz78_pkg, lz78_phrase_parser and lz78_phrase_checker.
module lz78_phrase_parser_tb;
    import lz78_pkg::*;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [SYM_W-1:0]    s_symbol      = '0;
    logic                s_last_symbol = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [NODE_W-1:0]   m_node_id;
    logic [NODE_W-1:0]   m_parent_id;
    logic [SYM_W-1:0]    m_edge_symbol;
    logic [OFFSET_W-1:0] m_start_offset;
    logic                m_dict_full;
    int                  fail_count;
    int                  pending;

    localparam int RANDOM_ITEMS = 320;

    bit               sender_idles    = 1'b1;
    bit               receiver_stalls = 1'b1;
    int               stall_left      = 0;
    int               sent;
    int               pick;
    int               text_len;
    logic [SYM_W-1:0] alphabet [4];
    logic [SYM_W-1:0] last_text [$];

    // Opening text, {last_symbol, symbol}: both symbol extremes, a walk into an
    // existing node, a phrase closed on the last symbol, partial phrases dropped
    // at a text end, and a repeating pattern that grows a chain.
    logic [SYM_W:0] opening_text [] = '{
        {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b1, 8'h01},
        {1'b0, 8'h00}, {1'b1, 8'hFF},
        {1'b1, 8'h00},
        {1'b1, 8'h7F},
        {1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b0, 8'h55},
        {1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b0, 8'h55},
        {1'b0, 8'hAA}, {1'b1, 8'h55}
    };

    lz78_phrase_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_last_symbol  (s_last_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_id      (m_node_id),
        .m_parent_id    (m_parent_id),
        .m_edge_symbol  (m_edge_symbol),
        .m_start_offset (m_start_offset),
        .m_dict_full    (m_dict_full)
    );

    lz78_phrase_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_last_symbol  (s_last_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_id      (m_node_id),
        .m_parent_id    (m_parent_id),
        .m_edge_symbol  (m_edge_symbol),
        .m_start_offset (m_start_offset),
        .m_dict_full    (m_dict_full),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result back-pressure: hold m_ready low for bursts of random length while
    // stalls are enabled, otherwise keep it high.
    always @(posedge aclk) begin
        if (receiver_stalls && stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one symbol, possibly after an idle burst, and hold it until the
    // transfer. s_valid stays high on return so the next call can go back to back.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_symbol      <= sym;
        s_last_symbol <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Drop valid and hold off until every predicted phrase has been taken.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin : stimulus
        // Hold reset, then release it; the table sweep afterwards keeps s_ready low
        // and send_symbol simply waits it out.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening.
        foreach (opening_text[k]) begin
            send_symbol(opening_text[k][SYM_W-1:0], opening_text[k][SYM_W]);
        end
        // Pause the sender with every result delivered at least once.
        wait_results_drained();

        // Random texts. Most come from a fixed four-symbol alphabet so the trie
        // grows deep and later texts walk long existing paths; some replay the
        // previous text to walk it again, and the rest are noise bytes with
        // stray text ends.
        for (int k = 0; k < 4; k++) begin
            alphabet[k] = SYM_W'($urandom_range(0, 255));
        end
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            pick            = $urandom_range(0, 9);
            if (pick < 3 && last_text.size() != 0) begin
                foreach (last_text[k]) begin
                    send_symbol(last_text[k], k == last_text.size() - 1);
                end
                sent += last_text.size();
            end else if (pick < 8) begin
                text_len = $urandom_range(2, 40);
                last_text.delete();
                repeat (text_len) last_text = {last_text, alphabet[$urandom_range(0, 3)]};
                foreach (last_text[k]) begin
                    send_symbol(last_text[k], k == last_text.size() - 1);
                end
                sent += text_len;
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    send_symbol(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                    sent++;
                end
            end
        end
        wait_results_drained();

        // Last part, no idling on either side: a one-symbol text for every byte
        // value, so each either creates a root child or walks an existing one
        // and drops that partial phrase at the text end.
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        for (int b = 0; b < 256; b++) begin
            send_symbol(SYM_W'(b), 1'b1);
        end

        // Drain, then watch a while longer for stray results.
        wait_results_drained();
        repeat (64) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit: far above the table sweep plus every symbol at its slowest
    // with the longest idle and stall bursts.
    initial begin : run_limit
        #48_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
